// ----- sv/lru_pkg.sv -----
`default_nettype none
package lru_pkg;

  localparam int FRAMES     = 16;
  localparam int FRAME_BITS = $clog2(FRAMES);
  localparam int CNT_BITS   = FRAME_BITS + 1;
  localparam int PAGE_BITS  = 16;
  localparam int COUNT_BITS = 16;

  localparam int IN_BITS  = 16;
  localparam int OUT_BITS = 40;

  localparam logic [CNT_BITS-1:0]   CAP_RESET = CNT_BITS'(4);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } lru_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic lookup;
    logic commit;
  } lru_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } lru_sts_t;

endpackage
`default_nettype wire

// ----- sv/lru_page_replacement_core.sv -----
`default_nettype none
// LRU page replacement unit: each transaction on the input stream carries one page
// reference; the unit answers with exactly one result telling whether it faulted, which
// frame now holds the page, which page (if any) was evicted and the saturating fault total.
// Each reference goes first through ST_LOOK, the parallel tag compare over all frames and
// the victim search among frames below the capacity, then through ST_UPD, which updates
// recency ranks, frame contents and the result register. A new reference is accepted only
// once the last one is in ST_UPD and the output is free, in the same cycle a result is
// loaded. The user must write frames_in_use through cfg_we/cfg_wdata only while no
// reference is in flight; the block itself does not enforce this. 0 acts as 1 and values
// above 16 act as 16. Frame state is valid straight out of reset, with no clearing pass.
module lru_page_replacement_core
  import lru_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CNT_BITS-1:0] cfg_wdata,     // frames_in_use
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [IN_BITS-1:0]  s_axis_tdata,  // page_number
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // fault, frame_index[4], evicted_valid, evicted_page[16], fault_count[16], pad[2]
  output logic [OUT_BITS-1:0]      m_axis_tdata
);

  lru_cmd_t cmd;
  lru_sts_t sts;

  lru_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  lru_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
`default_nettype wire

// ----- sv/lru_ctrl.sv -----
`default_nettype none
module lru_ctrl
  import lru_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_axis_tvalid,
  output logic          s_axis_tready,
  input  wire lru_sts_t sts,
  output lru_cmd_t      cmd
);

  lru_state_t state;
  lru_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (sts.out_free) begin
          state_next = s_axis_tvalid ? ST_LOOK : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_LOOK: begin
        cmd.lookup = 1'b1;
      end
      ST_UPD: begin
        // next transaction is taken in the same cycle the result is loaded
        s_axis_tready = sts.out_free;
        cmd.commit    = sts.out_free;
      end
      default: ;
    endcase
    cmd.load_in = s_axis_tready && s_axis_tvalid;
  end

endmodule
`default_nettype wire

// ----- sv/lru_dp.sv -----
`default_nettype none
module lru_dp
  import lru_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CNT_BITS-1:0] cfg_wdata,
  input  wire logic [IN_BITS-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OUT_BITS-1:0]      m_axis_tdata,
  input  wire lru_cmd_t            cmd,
  output lru_sts_t                 sts
);

  logic [CNT_BITS-1:0]   cap_cfg;
  logic [CNT_BITS-1:0]   cap_eff;
  logic [PAGE_BITS-1:0]  page_in;
  logic [PAGE_BITS-1:0]  frame_page [FRAMES];
  logic [FRAMES-1:0]     frame_valid;
  logic [FRAME_BITS-1:0] rank [FRAMES];
  logic [CNT_BITS-1:0]   filled;
  logic [COUNT_BITS-1:0] fault_total;
  logic [COUNT_BITS-1:0] fault_total_next;

  logic [FRAMES-1:0]     match_vec;
  logic [FRAMES-1:0]     max_vec;
  logic                  hit_any;
  logic [FRAME_BITS-1:0] hit_enc;
  logic [FRAME_BITS-1:0] victim_enc;

  logic                  hit;
  logic [FRAME_BITS-1:0] hit_idx;
  logic [FRAME_BITS-1:0] victim_idx;

  logic                  fill;
  logic [FRAME_BITS-1:0] tgt;
  logic [CNT_BITS-1:0]   old_rank;
  logic                  evict;

  logic                  out_fault;
  logic [FRAME_BITS-1:0] out_frame;
  logic                  out_ev_valid;
  logic [PAGE_BITS-1:0]  out_ev_page;
  logic [COUNT_BITS-1:0] out_count;

  // zero acts as one, anything above the frame count acts as the frame count
  always_comb begin
    if (cap_cfg == '0) begin
      cap_eff = CNT_BITS'(1);
    end else if (cap_cfg > CNT_BITS'(FRAMES)) begin
      cap_eff = CNT_BITS'(FRAMES);
    end else begin
      cap_eff = cap_cfg;
    end
  end

  // tag compare, lowest matching frame wins
  always_comb begin
    hit_enc = '0;
    for (int i = 0; i < FRAMES; i++) begin
      match_vec[i] = frame_valid[i] && (frame_page[i] == page_in);
    end
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_enc = FRAME_BITS'(i);
    end
    hit_any = |match_vec;
  end

  // oldest frame below the capacity; ranks there are distinct
  always_comb begin
    victim_enc = '0;
    for (int i = 0; i < FRAMES; i++) begin
      max_vec[i] = CNT_BITS'(i) < cap_eff;
      for (int j = 0; j < FRAMES; j++) begin
        if (j != i && CNT_BITS'(j) < cap_eff && rank[j] >= rank[i]) max_vec[i] = 1'b0;
      end
    end
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (max_vec[i]) victim_enc = FRAME_BITS'(i);
    end
  end

  always_comb begin
    fill  = (filled < cap_eff) && (filled < CNT_BITS'(FRAMES));
    evict = !hit && !fill;
    if (hit) begin
      tgt = hit_idx;
    end else if (fill) begin
      tgt = filled[FRAME_BITS-1:0];
    end else begin
      tgt = victim_idx;
    end
    // a newly filled frame is older than every resident one
    old_rank = (hit || evict) ? {1'b0, rank[tgt]} : CNT_BITS'(FRAMES);
    fault_total_next = (fault_total != COUNT_MAX) ? fault_total + 1'b1 : fault_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_cfg     <= CAP_RESET;
      frame_valid <= '0;
      filled      <= '0;
      fault_total <= '0;
      for (int i = 0; i < FRAMES; i++) rank[i] <= '0;
    end else begin
      if (cfg_we) cap_cfg <= cfg_wdata;
      if (cmd.commit) begin
        for (int i = 0; i < FRAMES; i++) begin
          if (FRAME_BITS'(i) == tgt) begin
            rank[i] <= '0;
          end else if (frame_valid[i] && ({1'b0, rank[i]} < old_rank)) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end
        if (!hit) begin
          fault_total <= fault_total_next;
          if (fill) begin
            frame_valid[tgt] <= 1'b1;
            filled           <= filled + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) page_in <= s_axis_tdata[PAGE_BITS-1:0];
    if (cmd.lookup) begin
      hit        <= hit_any;
      hit_idx    <= hit_enc;
      victim_idx <= victim_enc;
    end
    if (cmd.commit) begin
      if (!hit) frame_page[tgt] <= page_in;
      out_fault    <= !hit;
      out_frame    <= tgt;
      out_ev_valid <= evict;
      out_ev_page  <= evict ? frame_page[tgt] : '0;
      out_count    <= hit ? fault_total : fault_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign sts.out_free = !m_axis_tvalid || m_axis_tready;

  assign m_axis_tdata = {2'b00, out_count, out_ev_page, out_ev_valid, out_frame, out_fault};

endmodule
`default_nettype wire

// ----- sv/lru_chk.sv -----
`default_nettype none
module lru_chk
  import lru_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                cfg_we,
  input wire logic [CNT_BITS-1:0] cfg_wdata,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic [IN_BITS-1:0]  s_axis_tdata,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OUT_BITS-1:0] m_axis_tdata
);

  // no result appears out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> !m_axis_tdata[5])
    else $error("eviction reported on a hit");

  // evicted page reads zero when nothing was replaced
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[5]) |-> (m_axis_tdata[21:6] == '0))
    else $error("evicted page nonzero without eviction");

  // a fault always leaves a nonzero fault total
  a_fault_count: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[37:22] != '0))
    else $error("fault with zero fault total");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind lru_page_replacement_core lru_chk u_lru_chk (.*);
`default_nettype wire
